/* rtl/core/priority_led_status_arbiter_assert.svh */
// Assertion macros used by the checker of the status LED arbiter.
`ifndef PRIORITY_LED_STATUS_ARBITER_ASSERT_SVH
`define PRIORITY_LED_STATUS_ARBITER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PLSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PLSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/plsa_pkg.sv */
// Package with types, constants and the gamma table of the status LED arbiter.
`default_nettype none

package plsa_pkg;

    localparam int LEVELS_DEF     = 4;
    localparam int COUNT_BITS_DEF = 8;

    localparam int REQ_W    = 2;
    localparam int LEVEL_W  = 2;
    localparam int PIXEL_W  = 32;
    localparam int ACTIVE_W = 3;
    localparam int COLOR_W  = 24;
    localparam int BLINK_W  = 4;
    localparam int HALF_W   = 16;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [COLOR_W-1:0] COLOR_TOP_RST    = 24'h800080;
    localparam logic [COLOR_W-1:0] COLOR_SECOND_RST = 24'h0000FF;
    localparam logic [COLOR_W-1:0] COLOR_THIRD_RST  = 24'h969696;
    localparam logic [COLOR_W-1:0] COLOR_FOURTH_RST = 24'h200000;
    localparam logic [BLINK_W-1:0] BLINK_LEVELS_RST = 4'd2;
    localparam logic [HALF_W-1:0]  BLINK_HALF_RST   = 16'd250;

    typedef enum logic [REQ_W-1:0] {
        REQ_HOLD    = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_TICK    = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        REG_COLOR_TOP    = 3'd0,
        REG_COLOR_SECOND = 3'd1,
        REG_COLOR_THIRD  = 3'd2,
        REG_COLOR_FOURTH = 3'd3,
        REG_BLINK_LEVELS = 3'd4,
        REG_BLINK_HALF   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [PIXEL_W-1:0]  pixel_word;
        logic                pixel_send;
        logic [ACTIVE_W-1:0] active_now;
        logic                level_changed;
        logic                underflow_err;
        logic                count_saturated;
    } t_result;

    typedef logic [255:0][7:0] t_gamma_rom;

    // Entry v is the largest y with y^5 * 255^6 <= v^11, found by a binary search.
    function automatic t_gamma_rom build_gamma_rom();
        t_gamma_rom   rom;
        logic [127:0] p6;
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [7:0]   y;
        logic [7:0]   t;
        rom = '0;
        p6  = 128'd1;
        for (int k = 0; k < 6; k++) begin
            p6 = p6 * 128'd255;
        end
        for (int v = 0; v < 256; v++) begin
            lhs = 128'd1;
            for (int k = 0; k < 11; k++) begin
                lhs = lhs * 128'(v);
            end
            y = '0;
            for (int b = 7; b >= 0; b--) begin
                t   = y | (8'd1 << b);
                rhs = p6;
                for (int k = 0; k < 5; k++) begin
                    rhs = rhs * 128'(t);
                end
                if (rhs <= lhs) begin
                    y = t;
                end
            end
            rom[v] = y;
        end
        return rom;
    endfunction

    localparam t_gamma_rom GAMMA_ROM = build_gamma_rom();

    function automatic logic [7:0] gamma(input logic [7:0] v);
        return GAMMA_ROM[v];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/plsa_if.sv */
// Handshake interfaces for the request and pixel channels of the arbiter.
`default_nettype none

interface plsa_req_if
    import plsa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [LEVEL_W-1:0] level_id;

    modport source (output valid, output req_type, output level_id, input ready);
    modport sink (input valid, input req_type, input level_id, output ready);
endinterface

interface plsa_pix_if
    import plsa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PIXEL_W-1:0]  pixel_word;
    logic                pixel_send;
    logic [ACTIVE_W-1:0] active_now;
    logic                level_changed;
    logic                underflow_err;
    logic                count_saturated;

    modport source (
        output valid, output pixel_word, output pixel_send, output active_now,
        output level_changed, output underflow_err, output count_saturated,
        input ready
    );
    modport sink (
        input valid, input pixel_word, input pixel_send, input active_now,
        input level_changed, input underflow_err, input count_saturated,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/priority_led_status_arbiter.sv */
// Top level of the priority status arbiter that drives one RGB status LED.
//
// Requests arrive on i_req as hold, release, 1 ms tick or none beats with a level id.
// Every accepted request beat gives exactly one result beat on o_pix, carrying
// the gamma corrected GRB pixel word, a send flag, the active level and flags.
// The result is registered: the result of a beat accepted at one edge is valid
// after that edge. One request beat is taken every cycle while o_pix is not stalled.
// The output register holds a finished result while the receiver stalls, and
// i_req.ready is high whenever that register is empty or is read in the same
// cycle, so a stall on o_pix stops the request side after one beat at most.
// A synchronous active low reset clears all hold counts, selects no level,
// starts the blink in its on half and loads the register reset values.
// The APB port writes the colors and blink settings; pready is always high.
`default_nettype none

module priority_led_status_arbiter
    import plsa_pkg::*;
#(
    parameter int LEVELS     = LEVELS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    plsa_req_if.sink               i_req,
    plsa_pix_if.source             o_pix,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    localparam int IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LW = $clog2(LEVELS + 1);
    localparam logic [LW-1:0]         NO_LVL    = LW'(LEVELS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COLOR_W-1:0]    r_color [4];
    logic [BLINK_W-1:0]    r_blink_levels;
    logic [HALF_W-1:0]     r_blink_half;

    logic [COUNT_BITS-1:0] r_count [LEVELS];
    logic [COUNT_BITS-1:0] n_count [LEVELS];
    logic [LW-1:0]         r_active;
    logic [LW-1:0]         n_active;
    logic                  r_blink_on;
    logic                  n_blink_on;
    logic [HALF_W-1:0]     r_timer;
    logic [HALF_W-1:0]     n_timer;

    t_result               r_res;
    t_result               n_res;
    logic                  r_out_valid;

    logic                  accept;
    logic                  wr_en;
    t_reg_idx              reg_idx;
    logic [IW-1:0]         lvl_idx;
    logic                  lvl_ok;
    logic [LEVELS-1:0]     held_after;
    logic [LW-1:0]         fallback;
    logic [HALF_W-1:0]     half;
    logic [HALF_W-1:0]     timer_inc;
    logic                  send;
    logic                  underflow;
    logic                  saturated;
    logic                  cur_blinks;
    logic                  new_blinks;
    logic [COLOR_W-1:0]    color;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color[0]     <= COLOR_TOP_RST;
            r_color[1]     <= COLOR_SECOND_RST;
            r_color[2]     <= COLOR_THIRD_RST;
            r_color[3]     <= COLOR_FOURTH_RST;
            r_blink_levels <= BLINK_LEVELS_RST;
            r_blink_half   <= BLINK_HALF_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_COLOR_TOP:    r_color[0]     <= pwdata[COLOR_W-1:0];
                REG_COLOR_SECOND: r_color[1]     <= pwdata[COLOR_W-1:0];
                REG_COLOR_THIRD:  r_color[2]     <= pwdata[COLOR_W-1:0];
                REG_COLOR_FOURTH: r_color[3]     <= pwdata[COLOR_W-1:0];
                REG_BLINK_LEVELS: r_blink_levels <= pwdata[BLINK_W-1:0];
                REG_BLINK_HALF:   r_blink_half   <= pwdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COLOR_TOP:    prdata = DATA_W'(r_color[0]);
            REG_COLOR_SECOND: prdata = DATA_W'(r_color[1]);
            REG_COLOR_THIRD:  prdata = DATA_W'(r_color[2]);
            REG_COLOR_FOURTH: prdata = DATA_W'(r_color[3]);
            REG_BLINK_LEVELS: prdata = DATA_W'(r_blink_levels);
            REG_BLINK_HALF:   prdata = DATA_W'(r_blink_half);
            default:          prdata = '0;
        endcase
    end

    assign i_req.ready = !r_out_valid || o_pix.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign lvl_idx     = IW'(i_req.level_id);
    assign lvl_ok      = 32'(i_req.level_id) < LEVELS;
    assign half        = (r_blink_half == '0) ? HALF_W'(1) : r_blink_half;
    assign timer_inc   = r_timer + HALF_W'(1);
    assign cur_blinks  = (32'(r_active) < 32'd4) && r_blink_levels[r_active[1:0]];

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            held_after[i] = (r_count[i] != '0);
        end
        if (i_req.req_type == REQ_RELEASE && lvl_ok && r_count[lvl_idx] == COUNT_BITS'(1)) begin
            held_after[lvl_idx] = 1'b0;
        end
        fallback = NO_LVL;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (held_after[i]) begin
                fallback = LW'(i);
            end
        end
    end

    always_comb begin
        n_count    = r_count;
        n_active   = r_active;
        n_blink_on = r_blink_on;
        n_timer    = r_timer;
        send       = 1'b0;
        underflow  = 1'b0;
        saturated  = 1'b0;
        if ((i_req.req_type == REQ_HOLD || i_req.req_type == REQ_RELEASE) && lvl_ok) begin
            if (i_req.req_type == REQ_HOLD) begin
                if (r_count[lvl_idx] == COUNT_MAX) begin
                    saturated = 1'b1;
                end else begin
                    n_count[lvl_idx] = r_count[lvl_idx] + COUNT_BITS'(1);
                    if (r_count[lvl_idx] == '0 && LW'(i_req.level_id) < r_active) begin
                        n_active = LW'(i_req.level_id);
                    end
                end
            end else begin
                if (r_count[lvl_idx] == '0) begin
                    underflow = 1'b1;
                end else begin
                    n_count[lvl_idx] = r_count[lvl_idx] - COUNT_BITS'(1);
                    if (r_count[lvl_idx] == COUNT_BITS'(1)
                            && r_active == LW'(i_req.level_id)) begin
                        n_active = fallback;
                    end
                end
            end
            if (n_active != r_active) begin
                n_blink_on = 1'b1;
                n_timer    = '0;
                send       = (n_active != NO_LVL);
            end
        end else if (i_req.req_type == REQ_TICK) begin
            if (r_active != NO_LVL && cur_blinks) begin
                if (timer_inc >= half) begin
                    n_timer    = '0;
                    n_blink_on = !r_blink_on;
                    send       = 1'b1;
                end else begin
                    n_timer = timer_inc;
                end
            end
        end
    end

    assign new_blinks = (32'(n_active) < 32'd4) && r_blink_levels[n_active[1:0]];
    assign color      = (32'(n_active) < 32'd4) ? r_color[n_active[1:0]] : '0;

    always_comb begin
        if (n_active == NO_LVL || (new_blinks && !n_blink_on)) begin
            n_res.pixel_word = '0;
        end else begin
            n_res.pixel_word = {gamma(color[15:8]), gamma(color[23:16]),
                                gamma(color[7:0]), 8'd0};
        end
        n_res.pixel_send      = send;
        n_res.active_now      = ACTIVE_W'(n_active);
        n_res.level_changed   = (n_active != r_active);
        n_res.underflow_err   = underflow;
        n_res.count_saturated = saturated;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_count[i] <= '0;
            end
            r_active    <= NO_LVL;
            r_blink_on  <= 1'b1;
            r_timer     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count    <= n_count;
                r_active   <= n_active;
                r_blink_on <= n_blink_on;
                r_timer    <= n_timer;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_pix.valid           = r_out_valid;
    assign o_pix.pixel_word      = r_res.pixel_word;
    assign o_pix.pixel_send      = r_res.pixel_send;
    assign o_pix.active_now      = r_res.active_now;
    assign o_pix.level_changed   = r_res.level_changed;
    assign o_pix.underflow_err   = r_res.underflow_err;
    assign o_pix.count_saturated = r_res.count_saturated;

endmodule

`default_nettype wire

/* rtl/core/plsa_checker.sv */
// Port level checker of the status LED arbiter and its bind statement.
`default_nettype none

`include "priority_led_status_arbiter_assert.svh"

module plsa_checker
    import plsa_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [PIXEL_W-1:0]  i_pixel_word,
    input wire logic                i_pixel_send,
    input wire logic [ACTIVE_W-1:0] i_active_now,
    input wire logic                i_level_changed,
    input wire logic                i_underflow_err,
    input wire logic                i_count_saturated
);

    logic in_beat;
    logic out_hold;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_hold = i_out_valid && !i_out_ready;

    // Every request beat leaves a result in the output register.
    `PLSA_ASSERT_NEXT(a_beat_gives_result, i_clk, i_rst_n, in_beat, i_out_valid, "request beat lost")

    // No result appears without a request beat behind it.
    `PLSA_ASSERT_NEXT(a_no_invented_result, i_clk, i_rst_n, !in_beat && !out_hold, !i_out_valid, "result without request")

    // A rejected hold or release leaves the active level and the LED alone.
    `PLSA_ASSERT_NOW(a_error_is_quiet, i_clk, i_rst_n, i_out_valid && (i_underflow_err || i_count_saturated), !i_level_changed && !i_pixel_send, "error beat changed state")

    // A stalled result keeps its payload.
    `PLSA_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, out_hold, i_out_valid && $stable(i_pixel_word) && $stable(i_active_now) && $stable(i_pixel_send), "stalled result changed")

endmodule

bind priority_led_status_arbiter plsa_checker u_plsa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_req.valid),
    .i_in_ready        (i_req.ready),
    .i_out_valid       (o_pix.valid),
    .i_out_ready       (o_pix.ready),
    .i_pixel_word      (o_pix.pixel_word),
    .i_pixel_send      (o_pix.pixel_send),
    .i_active_now      (o_pix.active_now),
    .i_level_changed   (o_pix.level_changed),
    .i_underflow_err   (o_pix.underflow_err),
    .i_count_saturated (o_pix.count_saturated)
);

`default_nettype wire

/* bench/priority_led_status_arbiter_tb.sv */
// Testbench that checks the status LED arbiter against a predictor of its pixel beats.
`timescale 1ns / 100ps

module priority_led_status_arbiter_tb;
    import plsa_pkg::*;

    localparam int LEVEL_COUNT = LEVELS_DEF;
    localparam logic [ACTIVE_W-1:0] NO_LEVEL = ACTIVE_W'(LEVELS_DEF);

    class status_led_predictor;
        logic [7:0]                gamma_table [256];
        logic [COLOR_W-1:0]        level_color [LEVEL_COUNT];
        logic [BLINK_W-1:0]        blink_mask;
        logic [HALF_W-1:0]         half_ticks;
        logic [COUNT_BITS_DEF-1:0] hold_count [LEVEL_COUNT];
        logic [ACTIVE_W-1:0]       active_level;
        logic                      blink_on;
        logic [HALF_W-1:0]         blink_timer;
        t_result                   pending_pixels [$];
        int                        errors;

        function new();
            logic [127:0] target;
            logic [127:0] trial;
            int           y;
            y = 0;
            for (int v = 0; v < 256; v++) begin
                target = 128'd1;
                for (int k = 0; k < 11; k++) target = target * 128'(v);
                while (y < 255) begin
                    trial = 128'd1;
                    for (int k = 0; k < 5; k++) trial = trial * 128'(y + 1);
                    for (int k = 0; k < 6; k++) trial = trial * 128'd255;
                    if (trial > target) break;
                    y++;
                end
                gamma_table[v] = 8'(y);
            end
            level_color[0] = COLOR_TOP_RST;
            level_color[1] = COLOR_SECOND_RST;
            level_color[2] = COLOR_THIRD_RST;
            level_color[3] = COLOR_FOURTH_RST;
            blink_mask = BLINK_LEVELS_RST;
            half_ticks = BLINK_HALF_RST;
            foreach (hold_count[i]) hold_count[i] = '0;
            active_level = NO_LEVEL;
            blink_on = 1'b1;
            blink_timer = '0;
            errors = 0;
        endfunction

        function void set_register(t_reg_idx idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_COLOR_TOP:    level_color[0] = value[COLOR_W-1:0];
                REG_COLOR_SECOND: level_color[1] = value[COLOR_W-1:0];
                REG_COLOR_THIRD:  level_color[2] = value[COLOR_W-1:0];
                REG_COLOR_FOURTH: level_color[3] = value[COLOR_W-1:0];
                REG_BLINK_LEVELS: blink_mask = value[BLINK_W-1:0];
                REG_BLINK_HALF:   half_ticks = value[HALF_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [ACTIVE_W-1:0] highest_held();
            for (int i = 0; i < LEVEL_COUNT; i++) begin
                if (hold_count[i] != 0) return ACTIVE_W'(i);
            end
            return NO_LEVEL;
        endfunction

        function logic [PIXEL_W-1:0] shown_pixel();
            logic [COLOR_W-1:0] c;
            if (active_level >= NO_LEVEL) return '0;
            if (blink_mask[active_level] && !blink_on) return '0;
            c = level_color[active_level];
            return {gamma_table[c[15:8]], gamma_table[c[23:16]], gamma_table[c[7:0]], 8'h00};
        endfunction

        function void take_request(t_req rq, logic [LEVEL_W-1:0] lvl);
            t_result             r;
            logic [ACTIVE_W-1:0] prior;
            logic [HALF_W-1:0]   half;
            r = '0;
            prior = active_level;
            if (rq == REQ_HOLD || rq == REQ_RELEASE) begin
                if (rq == REQ_HOLD) begin
                    if (&hold_count[lvl]) begin
                        r.count_saturated = 1'b1;
                    end else begin
                        hold_count[lvl] = hold_count[lvl] + 1'b1;
                        if (hold_count[lvl] == 1 && {1'b0, lvl} < active_level)
                            active_level = {1'b0, lvl};
                    end
                end else begin
                    if (hold_count[lvl] == 0) begin
                        r.underflow_err = 1'b1;
                    end else begin
                        hold_count[lvl] = hold_count[lvl] - 1'b1;
                        if (hold_count[lvl] == 0 && active_level == {1'b0, lvl})
                            active_level = highest_held();
                    end
                end
                if (active_level != prior) begin
                    r.level_changed = 1'b1;
                    blink_on = 1'b1;
                    blink_timer = '0;
                    r.pixel_send = (active_level != NO_LEVEL);
                end
            end else if (rq == REQ_TICK) begin
                if (active_level != NO_LEVEL && blink_mask[active_level]) begin
                    half = (half_ticks == 0) ? HALF_W'(1) : half_ticks;
                    blink_timer = blink_timer + 1'b1;
                    if (blink_timer >= half) begin
                        blink_timer = '0;
                        blink_on = ~blink_on;
                        r.pixel_send = 1'b1;
                    end
                end
            end
            r.pixel_word = shown_pixel();
            r.active_now = active_level;
            pending_pixels.push_back(r);
        endfunction

        function void check_pixel(t_result got);
            t_result want;
            if (pending_pixels.size() == 0) begin
                $error("pixel beat arrived with no expectation waiting");
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got.pixel_word !== want.pixel_word) begin
                $error("pixel_word expected %h got %h", want.pixel_word, got.pixel_word);
                errors++;
            end
            if (got.pixel_send !== want.pixel_send) begin
                $error("pixel_send expected %b got %b", want.pixel_send, got.pixel_send);
                errors++;
            end
            if (got.active_now !== want.active_now) begin
                $error("active_now expected %0d got %0d", want.active_now, got.active_now);
                errors++;
            end
            if (got.level_changed !== want.level_changed) begin
                $error("level_changed expected %b got %b",
                       want.level_changed, got.level_changed);
                errors++;
            end
            if (got.underflow_err !== want.underflow_err) begin
                $error("underflow_err expected %b got %b",
                       want.underflow_err, got.underflow_err);
                errors++;
            end
            if (got.count_saturated !== want.count_saturated) begin
                $error("count_saturated expected %b got %b",
                       want.count_saturated, got.count_saturated);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    plsa_req_if req_bus ();
    plsa_pix_if pix_bus ();

    status_led_predictor predictor;
    t_result             pixel_beat;
    bit                  req_gaps_on;
    bit                  pix_stalls_on;

    priority_led_status_arbiter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_pix   (pix_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_bus.valid && pix_bus.ready) begin
                pixel_beat = '{pix_bus.pixel_word, pix_bus.pixel_send, pix_bus.active_now,
                               pix_bus.level_changed, pix_bus.underflow_err,
                               pix_bus.count_saturated};
                predictor.check_pixel(pixel_beat);
            end
            if (req_bus.valid && req_bus.ready)
                predictor.take_request(t_req'(req_bus.req_type), req_bus.level_id);
        end
    end

    function automatic int idle_cycles(bit allow, bit may_skip);
        int r;
        if (!allow) return 0;
        r = $urandom_range(0, 99);
        if (may_skip && r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    initial begin
        pix_bus.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pix_stalls_on && $urandom_range(0, 3) == 0) begin
                pix_bus.ready <= 1'b0;
                repeat (idle_cycles(1'b1, 1'b0)) @(posedge i_clk);
                pix_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input t_req rq, input logic [LEVEL_W-1:0] lvl);
        int gap;
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= rq;
        req_bus.level_id <= lvl;
        do @(posedge i_clk); while (!(req_bus.valid && req_bus.ready));
        gap = idle_cycles(req_gaps_on, 1'b1);
        if (gap > 0) begin
            req_bus.valid    <= 1'b0;
            req_bus.req_type <= t_req'($urandom_range(0, 3));
            req_bus.level_id <= LEVEL_W'($urandom_range(0, 3));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (predictor.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_register(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        predictor.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_color();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return {8'($urandom), 24'h000000};
        if (r < 30) return {8'($urandom), 24'hFFFFFF};
        return $urandom;
    endfunction

    task automatic configure_phase(input int phase);
        logic [DATA_W-1:0] half;
        logic [DATA_W-1:0] mask;
        int                r;
        write_register(REG_COLOR_TOP, pick_color());
        write_register(REG_COLOR_SECOND, pick_color());
        write_register(REG_COLOR_THIRD, pick_color());
        write_register(REG_COLOR_FOURTH, pick_color());
        r = $urandom_range(0, 99);
        if (phase == 0) half = {16'($urandom), 16'd0};
        else if (phase == 1) half = {16'($urandom), 16'hFFFF};
        else if (r < 70) half = {16'($urandom), 16'($urandom_range(0, 4))};
        else if (r < 95) half = {16'($urandom), 16'($urandom_range(5, 20))};
        else half = {16'($urandom), 16'hFFFF};
        if (phase == 0) mask = {28'($urandom), 4'hF};
        else if (phase == 1) mask = {28'($urandom), 4'h0};
        else mask = $urandom;
        write_register(REG_BLINK_LEVELS, mask);
        write_register(REG_BLINK_HALF, half);
    endtask

    task automatic run_mixed(input int count);
        logic [LEVEL_W-1:0] lvl;
        int                 r;
        int                 held [$];
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            lvl = LEVEL_W'($urandom_range(0, 3));
            if (r < 32) begin
                send_request(REQ_HOLD, lvl);
            end else if (r < 62) begin
                held.delete();
                for (int i = 0; i < LEVEL_COUNT; i++)
                    if (predictor.hold_count[i] != 0) held.push_back(i);
                if (held.size() != 0 && $urandom_range(0, 7) != 0)
                    lvl = LEVEL_W'(held[$urandom_range(0, held.size() - 1)]);
                send_request(REQ_RELEASE, lvl);
            end else if (r < 95) begin
                send_request(REQ_TICK, lvl);
            end else begin
                send_request(REQ_NONE, lvl);
            end
        end
    endtask

    task automatic run_saturation(input logic [LEVEL_W-1:0] lvl);
        repeat (262) begin
            if ($urandom_range(0, 9) == 0) send_request(REQ_TICK, LEVEL_W'($urandom));
            send_request(REQ_HOLD, lvl);
        end
        repeat (262) begin
            if ($urandom_range(0, 9) == 0) send_request(REQ_TICK, LEVEL_W'($urandom));
            send_request(REQ_RELEASE, lvl);
        end
    endtask

    initial begin
        predictor = new();
        req_gaps_on   = 1'b0;
        pix_stalls_on = 1'b0;
        i_rst_n          <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= REQ_NONE;
        req_bus.level_id <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: the second level blinks with a long half period.
        send_request(REQ_RELEASE, 2'd0);
        send_request(REQ_HOLD, 2'd3);
        send_request(REQ_HOLD, 2'd2);
        send_request(REQ_TICK, 2'd0);
        send_request(REQ_HOLD, 2'd0);
        send_request(REQ_HOLD, 2'd0);
        send_request(REQ_RELEASE, 2'd0);
        send_request(REQ_RELEASE, 2'd0);
        send_request(REQ_NONE, 2'd3);
        send_request(REQ_HOLD, 2'd1);
        send_request(REQ_TICK, 2'd3);
        send_request(REQ_RELEASE, 2'd1);
        send_request(REQ_RELEASE, 2'd2);
        send_request(REQ_RELEASE, 2'd3);
        send_request(REQ_RELEASE, 2'd3);
        send_request(REQ_TICK, 2'd1);
        wait_idle();

        // Every level blinks and a zero half period toggles on each tick.
        write_register(REG_COLOR_TOP, 32'h00FF_FFFF);
        write_register(REG_COLOR_SECOND, 32'hFF00_0000);
        write_register(REG_COLOR_THIRD, 32'h00FF_00FF);
        write_register(REG_COLOR_FOURTH, 32'h0000_FF00);
        write_register(REG_BLINK_LEVELS, 32'hFFFF_FFFF);
        write_register(REG_BLINK_HALF, 32'h0000_0000);
        send_request(REQ_HOLD, 2'd3);
        send_request(REQ_TICK, 2'd0);
        send_request(REQ_TICK, 2'd2);
        send_request(REQ_TICK, 2'd1);
        send_request(REQ_HOLD, 2'd1);
        send_request(REQ_TICK, 2'd0);
        send_request(REQ_RELEASE, 2'd1);
        send_request(REQ_TICK, 2'd3);
        send_request(REQ_RELEASE, 2'd3);
        wait_idle();

        for (int phase = 0; phase < 10; phase++) begin
            configure_phase(phase);
            req_gaps_on   = (phase % 3 != 2);
            pix_stalls_on = (phase % 3 != 2) && (phase != 4);
            if (phase == 3 || phase == 7)
                run_saturation(LEVEL_W'($urandom_range(0, 3)));
            run_mixed(100);
            wait_idle();
        end

        repeat (5) @(posedge i_clk);
        if (predictor.errors == 0 && predictor.pending_pixels.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
